### src/mexp_pkg.sv
package mexp_pkg;

   // operand width; base, modulus and exponent use their low OPERAND_BITS bits
   localparam int OPERAND_BITS = 32;
   localparam int CNT_W        = $clog2(OPERAND_BITS + 1);
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODULUS  = 1'b0,
      CSR_EXPONENT = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] MODULUS_RESET  = 32'd2;
   localparam logic [CSR_DATA_W-1:0] EXPONENT_RESET = 32'd1;

   // multiplier launch / completion handshake
   typedef struct packed {
      logic                    start;
      logic [OPERAND_BITS-1:0] op_a;
      logic [OPERAND_BITS-1:0] op_b;
   } mul_req_type;

   typedef struct packed {
      logic                    done;
      logic [OPERAND_BITS-1:0] product;
   } mul_rsp_type;

endpackage

### src/modular_exponentiation.sv
// Modular exponentiation, right-to-left square and multiply, bit-serial.
// Per item: reduce the base, then for each of the OPERAND_BITS exponent bits a multiply
//   when the bit is set and always a square; each modular multiply is bit-serial.
// Throughput: one item at a time; a new item is taken once busy drops.
// Modulus zero: result 0, registered in the cycle after start. Receiver cannot stall rsp_valid.
// Reset (synchronous, active high): idle, modulus = 2, exponent = 1.
module modular_exponentiation (
   input  logic                                clock,
   input  logic                                reset,
   // item in
   input  logic                                start,
   output logic                                busy,
   input  logic [31:0]                         req_base,
   // result out
   output logic                                rsp_valid,
   output logic [31:0]                         rsp_power,
   // configuration
   input  logic                                csr_write,
   input  logic [mexp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mexp_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int W = mexp_pkg::OPERAND_BITS;

   typedef enum logic [2:0] {
      IDLE,
      REDUCE,   // base mod m, done as base * 1
      NEXT,     // pick multiply or square for the current exponent bit, or finish
      MUL,      // acc = acc * base
      SQR       // base = base * base
   } state_type;

   state_type                    state_ff, state_in;
   logic [31:0]                  modulus_ff, modulus_in;
   logic [31:0]                  exponent_ff, exponent_in;
   logic [W-1:0]                 base_ff, base_in;     // running base power
   logic [W-1:0]                 acc_ff, acc_in;
   logic [W-1:0]                 exp_ff, exp_in;       // exponent, shifted right per bit
   logic [mexp_pkg::CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [31:0]                  rsp_power_ff, rsp_power_in;
   mexp_pkg::mul_req_type        mul_req_ff, mul_req_in;
   mexp_pkg::mul_rsp_type        mul_rsp;

   logic [W-1:0] mod_op;

   assign mod_op = modulus_ff[W-1:0];

   mexp_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (mod_op),
      .mul_req (mul_req_ff),
      .mul_rsp (mul_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      modulus_in   = modulus_ff;
      exponent_in  = exponent_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_power_in = rsp_power_ff;
      mul_req_in   = mul_req_ff;
      mul_req_in.start = 1'b0;

      // config writes are to arrive only while idle; the block does not enforce it
      if (csr_write) begin
         case (mexp_pkg::csr_index_type'(csr_index))
            mexp_pkg::CSR_MODULUS:  modulus_in  = csr_data;
            mexp_pkg::CSR_EXPONENT: exponent_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         IDLE: begin
            if (start) begin
               if (mod_op == '0) begin
                  // no reduction possible: result fixed at zero
                  rsp_valid_in = 1'b1;
                  rsp_power_in = '0;
               end else begin
                  // 1 mod m is 0 only for m == 1
                  acc_in     = (mod_op == W'(1)) ? '0 : W'(1);
                  exp_in     = exponent_ff[W-1:0];
                  bit_cnt_in = mexp_pkg::CNT_W'(W);
                  mul_req_in.start = 1'b1;
                  mul_req_in.op_a  = req_base[W-1:0];
                  mul_req_in.op_b  = W'(1);
                  state_in   = REDUCE;
               end
            end
         end
         REDUCE: begin
            if (mul_rsp.done) begin
               base_in  = mul_rsp.product;
               state_in = NEXT;
            end
         end
         NEXT: begin
            if (bit_cnt_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_power_in = 32'(acc_ff);
               state_in     = IDLE;
            end else if (exp_ff[0]) begin
               mul_req_in.start = 1'b1;
               mul_req_in.op_a  = acc_ff;
               mul_req_in.op_b  = base_ff;
               state_in = MUL;
            end else begin
               mul_req_in.start = 1'b1;
               mul_req_in.op_a  = base_ff;
               mul_req_in.op_b  = base_ff;
               state_in = SQR;
            end
         end
         MUL: begin
            if (mul_rsp.done) begin
               acc_in = mul_rsp.product;
               mul_req_in.start = 1'b1;
               mul_req_in.op_a  = base_ff;
               mul_req_in.op_b  = base_ff;
               state_in = SQR;
            end
         end
         SQR: begin
            if (mul_rsp.done) begin
               base_in    = mul_rsp.product;
               exp_in     = exp_ff >> 1;
               bit_cnt_in = bit_cnt_ff - mexp_pkg::CNT_W'(1);
               state_in   = NEXT;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      acc_ff       <= acc_in;
      exp_ff       <= exp_in;
      bit_cnt_ff   <= bit_cnt_in;
      rsp_power_ff <= rsp_power_in;
      mul_req_ff.op_a <= mul_req_in.op_a;
      mul_req_ff.op_b <= mul_req_in.op_b;
      if (reset) begin
         state_ff         <= IDLE;
         modulus_ff       <= mexp_pkg::MODULUS_RESET;
         exponent_ff      <= mexp_pkg::EXPONENT_RESET;
         rsp_valid_ff     <= 1'b0;
         mul_req_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         modulus_ff       <= modulus_in;
         exponent_ff      <= exponent_in;
         rsp_valid_ff     <= rsp_valid_in;
         mul_req_ff.start <= mul_req_in.start;
      end
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = rsp_power_ff;

endmodule

### src/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier, op_a scanned MSB first.
// Needs op_b <= modulus. One op_a bit per cycle, all OPERAND_BITS bits of op_a.
module mexp_mulmod (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mexp_pkg::OPERAND_BITS-1:0] modulus,
   input  mexp_pkg::mul_req_type           mul_req,
   output mexp_pkg::mul_rsp_type           mul_rsp
);

   localparam int W = mexp_pkg::OPERAND_BITS;

   logic [W-1:0]                 a_ff, a_in;
   logic [W-1:0]                 b_ff, b_in;
   logic [W-1:0]                 r_ff, r_in;
   logic [mexp_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;

   logic [W+1:0] sum;
   logic [W+2:0] diff1, diff2;
   logic [W-1:0] reduced;

   // t = 2r + a_i*b < 3m; try t-2m, then t-m
   always_comb begin
      sum     = {1'b0, r_ff, 1'b0} + {2'b00, (a_ff[W-1] ? b_ff : {W{1'b0}})};
      diff1   = {1'b0, sum} - {3'b000, modulus};
      diff2   = {1'b0, sum} - {2'b00, modulus, 1'b0};
      if (!diff2[W+2]) begin
         reduced = diff2[W-1:0];
      end else if (!diff1[W+2]) begin
         reduced = diff1[W-1:0];
      end else begin
         reduced = sum[W-1:0];
      end
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         a_in    = mul_req.op_a;
         b_in    = mul_req.op_b;
         r_in    = '0;
         cnt_in  = mexp_pkg::CNT_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         a_in   = {a_ff[W-2:0], 1'b0};
         r_in   = reduced;
         cnt_in = cnt_ff - mexp_pkg::CNT_W'(1);
         if (cnt_ff == mexp_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = r_ff;

endmodule

### dv/mexp_checker.sv
`timescale 1ns / 100ps

// Watches the item and result channels and the register port of the
// modular exponentiation block, predicts each power and compares it.
module mexp_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [31:0]                      req_base,
   input  logic                             rsp_valid,
   input  logic [31:0]                      rsp_power,
   input  logic                             csr_write,
   input  logic [mexp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mexp_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               mismatches,
   output int                               outstanding
);

   logic [31:0] modulus_q;
   logic [31:0] exponent_q;
   logic [31:0] expected_power [$];
   logic [31:0] oldest_power;

   // right-to-left square and multiply, 64-bit products
   function automatic logic [31:0] predict_power(input logic [31:0] base,
                                                 input logic [31:0] modulus,
                                                 input logic [31:0] exponent);
      logic [63:0] acc;
      logic [63:0] square;
      if (modulus == 32'd0)
         return 32'd0;
      acc    = 64'd1 % modulus;
      square = base % modulus;
      for (int i = 0; i < mexp_pkg::OPERAND_BITS; i++) begin
         if (exponent[i])
            acc = (acc * square) % modulus;
         square = (square * square) % modulus;
      end
      return acc[31:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         modulus_q   <= mexp_pkg::MODULUS_RESET;
         exponent_q  <= mexp_pkg::EXPONENT_RESET;
         expected_power.delete();
         outstanding <= 0;
         mismatches  <= 0;
      end else begin
         // a result arriving at an accept edge belongs to the older item
         if (rsp_valid) begin
            if (expected_power.size() == 0) begin
               $error("rsp_power: no item waiting, expected none, actual %08h", rsp_power);
               mismatches <= mismatches + 1;
            end else begin
               oldest_power = expected_power.pop_front();
               if (rsp_power !== oldest_power) begin
                  $error("rsp_power: expected %08h, actual %08h", oldest_power, rsp_power);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (start && !busy)
            expected_power.push_back(predict_power(req_base, modulus_q, exponent_q));
         if (csr_write) begin
            case (csr_index)
               mexp_pkg::CSR_MODULUS:  modulus_q  <= csr_data;
               mexp_pkg::CSR_EXPONENT: exponent_q <= csr_data;
               default: ;
            endcase
         end
         outstanding <= expected_power.size();
      end
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   // wait budget for a worst-case item, rounded up
   localparam int ITEM_CYCLES   = 2300;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_ITEMS   = 20;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [31:0]                      req_base;
   logic                             rsp_valid;
   logic [31:0]                      rsp_power;
   logic                             csr_write;
   logic [mexp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mexp_pkg::CSR_DATA_W-1:0]  csr_data;

   int          fail_count;
   int          items_waiting;
   int          idle_pct;
   logic [31:0] modulus_now;
   logic [31:0] exponent_now;

   modular_exponentiation i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_base  (req_base),
      .rsp_valid (rsp_valid),
      .rsp_power (rsp_power),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   mexp_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_base    (req_base),
      .rsp_valid   (rsp_valid),
      .rsp_power   (rsp_power),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (fail_count),
      .outstanding (items_waiting)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop for a run that hangs
   initial begin
      #(30_000_000);
      $display("status: fail");
      $finish;
   end

   // Called at a falling edge. Optional idle cycles first, then start is
   // held until the block takes the item; returns on the next falling edge
   // with start still high, so a back-to-back item never toggles it.
   task automatic send_base(input logic [31:0] base);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_base <= base;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // drop start and wait until every result is back and the block is idle
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (items_waiting != 0 || busy);
      @(negedge clock);
   endtask

   // register writes only when idle; modulus then exponent on back-to-back edges
   task automatic program_key(input logic [31:0] modulus, input logic [31:0] exponent);
      drain();
      csr_write <= 1'b1;
      csr_index <= mexp_pkg::CSR_MODULUS;
      csr_data  <= modulus;
      @(negedge clock);
      csr_index <= mexp_pkg::CSR_EXPONENT;
      csr_data  <= exponent;
      @(negedge clock);
      csr_write    <= 1'b0;
      modulus_now  = modulus;
      exponent_now = exponent;
   endtask

   function automatic logic [31:0] pick_modulus();
      case ($urandom_range(9))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return 32'd2;
         3:       return 32'hFFFF_FFFF;
         4, 5:    return $urandom_range(65535, 3);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_exponent();
      case ($urandom_range(7))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return 32'hFFFF_FFFF;
         3:       return $urandom_range(65537, 2);
         default: return $urandom;
      endcase
   endfunction

   // bases around the modulus edges, reduced ones and raw 32-bit noise
   function automatic logic [31:0] pick_base(input logic [31:0] modulus);
      case ($urandom_range(9))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return modulus - 32'd1;
         3:       return modulus;
         4:       return 32'hFFFF_FFFF;
         5, 6:    return (modulus == 32'd0) ? $urandom : $urandom % modulus;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_base     = '0;
      csr_write    = 1'b0;
      csr_index    = mexp_pkg::CSR_MODULUS;
      csr_data     = '0;
      idle_pct     = 0;
      modulus_now  = mexp_pkg::MODULUS_RESET;
      exponent_now = mexp_pkg::EXPONENT_RESET;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed: reset key (modulus 2, exponent 1) ---
      send_base(32'd0);
      send_base(32'd1);
      send_base(32'hFFFF_FFFF);

      // widest key, every exponent bit set
      program_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_base(32'd0);
      send_base(32'd1);
      send_base(32'hFFFF_FFFE);
      send_base(32'hFFFF_FFFF);
      send_base(32'h8000_0000);

      // exponent zero gives one
      program_key(32'hFFFF_FFFF, 32'd0);
      send_base(32'd5);
      send_base(32'hFFFF_FFFF);

      // modulus one gives zero, even with exponent zero
      program_key(32'd1, 32'd0);
      send_base(32'd7);
      program_key(32'd1, 32'hFFFF_FFFF);
      send_base(32'hFFFF_FFFF);

      // modulus zero: result pinned at zero, comes back fast
      program_key(32'd0, 32'h1234_5678);
      send_base(32'd123);
      send_base(32'hFFFF_FFFF);

      // textbook RSA key pair, encrypt then decrypt
      program_key(32'd3233, 32'd17);
      send_base(32'd65);
      send_base(32'd3233);
      program_key(32'd3233, 32'd2753);
      send_base(32'd2790);

      // large prime modulus, single high exponent bit
      program_key(32'hFFFF_FFFB, 32'h8000_0000);
      send_base(32'h1234_5678);
      send_base(32'hFFFF_FFFC);

      // --- random phases: fresh key each phase, cycling idle modes ---
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         program_key(pick_modulus(), pick_exponent());
         case (phase % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 84;
            default: idle_pct = 21;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // mid-phase hold-off on odd phases until the pipe is empty
            if (n == PHASE_ITEMS / 2 && phase % 2 == 1)
               drain();
            send_base(pick_base(modulus_now));
         end
      end

      // --- wind down ---
      drain();
      repeat (ITEM_CYCLES) @(posedge clock);
      if (fail_count == 0 && items_waiting == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
